@@ rtl/tse_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers of the TCP SACK option extractor.
package tse_pkg;

	localparam int unsigned POSITION_BITS_DEFAULT = 16;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	localparam int unsigned CNT_W = 32;
	localparam int unsigned EDGE_W = 32;

	// Kinds of event the parser hands to the counter side.
	localparam logic [1:0] EV_PAIR = 2'd0;
	localparam logic [1:0] EV_ONE = 2'd1;
	localparam logic [1:0] EV_TWO = 2'd2;
	localparam logic [1:0] EV_THREE = 2'd3;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2*EDGE_W-1:0] edges;
	} tse_ev_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		cnt_t r;
		r = (v == '1) ? v : v + cnt_t'(1);
		return r;
	endfunction

endpackage

@@ rtl/tse_byte_if.sv @@
`timescale 1ns / 1ps
// Byte stream channel carrying Ethernet frame bytes.
interface tse_byte_if;
	logic valid;
	logic ready;
	logic [7:0] frame_byte;
	logic frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink (input valid, input frame_byte, input frame_end, output ready);
	modport mon (input valid, input frame_byte, input frame_end, input ready);
endinterface

@@ rtl/tse_range_if.sv @@
`timescale 1ns / 1ps
// Result channel carrying one SACK range and the running counters.
interface tse_range_if;
	logic valid;
	logic ready;
	logic [31:0] left_edge;
	logic [31:0] right_edge;
	logic [31:0] range_number;
	logic [31:0] one_range_count;
	logic [31:0] two_range_count;
	logic [31:0] three_range_count;

	modport source (output valid, output left_edge, output right_edge, output range_number,
		output one_range_count, output two_range_count, output three_range_count,
		input ready);
	modport sink (input valid, input left_edge, input right_edge, input range_number,
		input one_range_count, input two_range_count, input three_range_count,
		output ready);
	modport mon (input valid, input left_edge, input right_edge, input range_number,
		input one_range_count, input two_range_count, input three_range_count,
		input ready);
endinterface

@@ rtl/tse_front.sv @@
`timescale 1ns / 1ps
// Frame parser: walks Ethernet, IPv4 and TCP headers and emits SACK events.
module tse_front import tse_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	tse_byte_if.sink frame,
	input  logic ev_ready,
	output logic ev_valid,
	output tse_ev_t ev
);

	localparam logic [3:0] PH_ETH = 4'd0;
	localparam logic [3:0] PH_IP = 4'd1;
	localparam logic [3:0] PH_TCP = 4'd2;
	localparam logic [3:0] PH_OPTWAIT = 4'd3;
	localparam logic [3:0] PH_KIND = 4'd4;
	localparam logic [3:0] PH_OPTLEN = 4'd5;
	localparam logic [3:0] PH_SKIP = 4'd6;
	localparam logic [3:0] PH_SACKLEN = 4'd7;
	localparam logic [3:0] PH_EDGE = 4'd8;
	localparam logic [3:0] PH_IDLE = 4'd9;

	localparam logic [7:0] KIND_END = 8'd0;
	localparam logic [7:0] KIND_NOP = 8'd1;
	localparam logic [7:0] KIND_SACK = 8'd5;

	typedef logic [POSITION_BITS-1:0] pos_t;

	logic [3:0] phase_q, phase_d;
	pos_t pos_q;
	logic [7:0] eth_hi_q, eth_hi_d;
	logic [7:0] tcp_start_q, tcp_start_d;
	logic [7:0] opt_end_q, opt_end_d;
	logic [7:0] skip_q, skip_d;
	logic [4:0] ranges_q, ranges_d;
	logic [55:0] shift_q, shift_d;
	logic [2:0] cnt_q, cnt_d;

	logic acc;
	logic [7:0] b;
	logic [7:0] skip_dec;
	logic [7:0] len_m2;
	logic [4:0] nranges;
	logic [4:0] ranges_dec;
	logic [3:0] kind_phase;

	assign frame.ready = ev_ready;
	assign acc = frame.valid && ev_ready;
	assign b = frame.frame_byte;
	assign skip_dec = skip_q - 8'd1;
	assign len_m2 = b - 8'd2;
	assign nranges = (b < 8'd2) ? 5'd0 : len_m2[7:3];
	assign ranges_dec = ranges_q - 5'd1;

	always_comb begin
		if (pos_q >= pos_t'(opt_end_q) || b == KIND_END) begin
			kind_phase = PH_IDLE;
		end else if (b == KIND_NOP) begin
			kind_phase = PH_KIND;
		end else if (b == KIND_SACK) begin
			kind_phase = PH_SACKLEN;
		end else begin
			kind_phase = PH_OPTLEN;
		end
	end

	always_comb begin
		phase_d = phase_q;
		eth_hi_d = eth_hi_q;
		tcp_start_d = tcp_start_q;
		opt_end_d = opt_end_q;
		skip_d = skip_q;
		ranges_d = ranges_q;
		shift_d = shift_q;
		cnt_d = cnt_q;
		ev_valid = 1'b0;
		ev.kind = EV_PAIR;
		ev.edges = {shift_q, b};
		unique case (phase_q)
			PH_ETH: begin
				if (pos_q == pos_t'(12)) begin
					eth_hi_d = b;
				end else if (pos_q == pos_t'(13)) begin
					phase_d = (eth_hi_q == 8'h08 && b == 8'h00) ? PH_IP : PH_IDLE;
				end
			end
			PH_IP: begin
				if (pos_q == pos_t'(14)) begin
					tcp_start_d = 8'd14 + {4'd0, b[3:0]} * 8'd4;
				end else if (pos_q == pos_t'(23)) begin
					phase_d = (b == 8'd6) ? PH_TCP : PH_IDLE;
				end
			end
			PH_TCP: begin
				if (pos_q == pos_t'(tcp_start_q) + pos_t'(12)) begin
					opt_end_d = tcp_start_q + {4'd0, b[7:4]} * 8'd4;
					phase_d = PH_OPTWAIT;
				end
			end
			PH_OPTWAIT: begin
				if (pos_q == pos_t'(tcp_start_q) + pos_t'(20)) begin
					phase_d = kind_phase;
				end
			end
			PH_KIND: begin
				phase_d = kind_phase;
			end
			PH_OPTLEN: begin
				if (b < 8'd2) begin
					phase_d = PH_IDLE;
				end else if (b == 8'd2) begin
					phase_d = PH_KIND;
				end else begin
					skip_d = len_m2;
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 8'd0) begin
					phase_d = PH_KIND;
				end
			end
			PH_SACKLEN: begin
				if (nranges == 5'd1) begin
					ev_valid = acc;
					ev.kind = EV_ONE;
				end else if (nranges == 5'd2) begin
					ev_valid = acc;
					ev.kind = EV_TWO;
				end else if (nranges == 5'd3) begin
					ev_valid = acc;
					ev.kind = EV_THREE;
				end
				if (nranges == 5'd0) begin
					phase_d = PH_KIND;
				end else begin
					ranges_d = nranges;
					shift_d = '0;
					cnt_d = 3'd0;
					phase_d = PH_EDGE;
				end
			end
			PH_EDGE: begin
				if (cnt_q == 3'd7) begin
					ev_valid = acc;
					ev.kind = EV_PAIR;
					cnt_d = 3'd0;
					shift_d = '0;
					ranges_d = ranges_dec;
					if (ranges_dec == 5'd0) begin
						phase_d = PH_KIND;
					end
				end else begin
					shift_d = {shift_q[47:0], b};
					cnt_d = cnt_q + 3'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ETH;
			pos_q <= '0;
			eth_hi_q <= '0;
			tcp_start_q <= '0;
			opt_end_q <= '0;
			skip_q <= '0;
			ranges_q <= '0;
			shift_q <= '0;
			cnt_q <= '0;
		end else if (acc) begin
			if (frame.frame_end) begin
				phase_q <= PH_ETH;
				pos_q <= '0;
				eth_hi_q <= '0;
				tcp_start_q <= '0;
				opt_end_q <= '0;
				skip_q <= '0;
				ranges_q <= '0;
				shift_q <= '0;
				cnt_q <= '0;
			end else begin
				phase_q <= phase_d;
				if (pos_q != '1) begin
					pos_q <= pos_q + pos_t'(1);
				end
				eth_hi_q <= eth_hi_d;
				tcp_start_q <= tcp_start_d;
				opt_end_q <= opt_end_d;
				skip_q <= skip_d;
				ranges_q <= ranges_d;
				shift_q <= shift_d;
				cnt_q <= cnt_d;
			end
		end
	end

endmodule

@@ rtl/tse_queue.sv @@
`timescale 1ns / 1ps
// Small event queue decoupling the parser from the counter and output side.
module tse_queue import tse_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tse_ev_t push_ev,
	output logic not_full,
	input  logic pop,
	output logic head_valid,
	output tse_ev_t head_ev
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

	tse_ev_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign not_full = (count_q != CNT_QW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_ev = mem_q[rd_ptr_q];
	assign do_push = push && not_full;
	assign do_pop = pop && head_valid;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

endmodule

@@ rtl/tse_back.sv @@
`timescale 1ns / 1ps
// Counter side: applies SACK events in order and drives the result register.
module tse_back import tse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  tse_ev_t head_ev,
	output logic pop,
	tse_range_if.source sack
);

	cnt_t range_q;
	cnt_t one_q;
	cnt_t two_q;
	cnt_t three_q;
	logic out_valid_q;
	logic [EDGE_W-1:0] left_q;
	logic [EDGE_W-1:0] right_q;
	cnt_t out_range_q;
	cnt_t out_one_q;
	cnt_t out_two_q;
	cnt_t out_three_q;

	logic slot_free;
	logic is_pair;
	cnt_t range_inc;

	assign slot_free = !out_valid_q || sack.ready;
	assign is_pair = (head_ev.kind == EV_PAIR);
	assign pop = head_valid && (!is_pair || slot_free);
	assign range_inc = sat_inc(range_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= '0;
			one_q <= '0;
			two_q <= '0;
			three_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (sack.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (head_ev.kind)
					EV_PAIR: begin
						range_q <= range_inc;
						out_valid_q <= 1'b1;
					end
					EV_ONE: one_q <= sat_inc(one_q);
					EV_TWO: two_q <= sat_inc(two_q);
					EV_THREE: three_q <= sat_inc(three_q);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_pair) begin
			left_q <= head_ev.edges[2*EDGE_W-1:EDGE_W];
			right_q <= head_ev.edges[EDGE_W-1:0];
			out_range_q <= range_inc;
			out_one_q <= one_q;
			out_two_q <= two_q;
			out_three_q <= three_q;
		end
	end

	assign sack.valid = out_valid_q;
	assign sack.left_edge = left_q;
	assign sack.right_edge = right_q;
	assign sack.range_number = out_range_q;
	assign sack.one_range_count = out_one_q;
	assign sack.two_range_count = out_two_q;
	assign sack.three_range_count = out_three_q;

endmodule

@@ rtl/tcp_sack_option_extractor.sv @@
`timescale 1ns / 1ps
// Top level of the TCP SACK option extractor.
//
// The frame channel takes an Ethernet frame one byte per transfer, starting at the
// destination MAC, with frame_end set on the last byte. IPv4 frames that carry TCP
// have their option area walked, and every SACK block found gives one transfer on
// the sack channel: left and right edge, a running range number, and the counts of
// SACK options seen with one, two and three ranges. All counters saturate.
// The parser takes one byte every cycle while the event queue has room. A result
// reaches the sack channel after the transfer of the byte that completes its edge
// pair, passing first through the event queue and then the output register.
// The parser and the counter side are joined by a queue of QUEUE_DEPTH events. When
// the receiver stalls, results wait in the output register and the queue while bytes
// are still taken; frame.ready falls only once the queue is full.
// Reset clears the parser, the queue, the counters and the output valid flag. The end
// of a frame returns the parser to its start state and keeps the counters.
module tcp_sack_option_extractor import tse_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	tse_byte_if.sink frame,
	tse_range_if.source sack
);

	logic ev_valid;
	tse_ev_t ev;
	logic q_not_full;
	logic q_pop;
	logic head_valid;
	tse_ev_t head_ev;

	tse_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame),
		.ev_ready(q_not_full),
		.ev_valid(ev_valid),
		.ev(ev)
	);

	tse_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(ev_valid),
		.push_ev(ev),
		.not_full(q_not_full),
		.pop(q_pop),
		.head_valid(head_valid),
		.head_ev(head_ev)
	);

	tse_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_ev(head_ev),
		.pop(q_pop),
		.sack(sack)
	);

endmodule

@@ rtl/tse_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the TCP SACK option extractor and its bind.
module tse_checker (
	input logic clk,
	input logic arst_n,
	tse_range_if.source sack
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sack.valid && !sack.ready |=> sack.valid)
		else $error("Result withdrawn before its transfer.");

	a_reset: assert property (@(posedge clk) !arst_n |=> !sack.valid)
		else $error("Result offered right after reset.");

	a_range_up: assert property (@(posedge clk) disable iff (!arst_n)
		sack.valid && sack.ready |=> !sack.valid || sack.range_number == 32'hFFFF_FFFF
			|| sack.range_number > $past(sack.range_number))
		else $error("Range number did not advance between results.");

	a_counts_up: assert property (@(posedge clk) disable iff (!arst_n)
		sack.valid && sack.ready |=> !sack.valid
			|| (sack.one_range_count >= $past(sack.one_range_count)
			&& sack.two_range_count >= $past(sack.two_range_count)
			&& sack.three_range_count >= $past(sack.three_range_count)))
		else $error("Range counters went backwards.");

endmodule

bind tcp_sack_option_extractor tse_checker u_tse_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sack(sack)
);

@@ dv/tcp_sack_option_extractor_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench that streams Ethernet frames and checks every SACK range result.
module tcp_sack_option_extractor_tb;
	import tse_pkg::*;

	localparam int unsigned POS_W = POSITION_BITS_DEFAULT;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] OPT_EOL = 8'd0;
	localparam logic [7:0] OPT_NOP = 8'd1;
	localparam logic [7:0] OPT_MSS = 8'd2;
	localparam logic [7:0] OPT_SACK = 8'd5;
	localparam logic [7:0] OPT_TSTAMP = 8'd8;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 16;

	typedef enum logic [3:0] {
		ST_ETH, ST_IP, ST_TCP, ST_OPT_WAIT, ST_KIND, ST_OPT_LEN,
		ST_SKIP, ST_SACK_LEN, ST_EDGES, ST_IDLE
	} walk_phase_e;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} frame_item_t;

	typedef struct {
		logic [31:0] left_edge;
		logic [31:0] right_edge;
		cnt_t range_number;
		cnt_t one_count;
		cnt_t two_count;
		cnt_t three_count;
	} sack_range_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic [7:0] byte_data = 8'h00;
	logic byte_last = 1'b0;
	logic sack_ready = 1'b0;

	tse_byte_if frame_if ();
	tse_range_if sack_if ();

	assign frame_if.valid = byte_valid;
	assign frame_if.frame_byte = byte_data;
	assign frame_if.frame_end = byte_last;
	assign sack_if.ready = sack_ready;

	tcp_sack_option_extractor u_top (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_if),
		.sack(sack_if)
	);

	frame_item_t frame_items[$];
	logic [7:0] opt_buf[$];
	sack_range_t sack_ranges_due[$];
	int unsigned errors = 0;
	int unsigned ranges_checked = 0;

	// Parser state of the predictor.
	logic [POS_W-1:0] walk_pos = '0;
	walk_phase_e walk_phase = ST_ETH;
	logic [7:0] etype_hi = 8'h00;
	logic [7:0] tcp_base = 8'h00;
	logic [7:0] opt_limit = 8'h00;
	logic [7:0] skip_left = 8'h00;
	logic [4:0] pairs_left = 5'd0;
	logic [63:0] edge_acc = 64'd0;
	logic [2:0] edge_cnt = 3'd0;
	cnt_t range_cnt = '0;
	cnt_t one_cnt = '0;
	cnt_t two_cnt = '0;
	cnt_t three_cnt = '0;

	function automatic cnt_t saturating_up(input cnt_t v);
		return (v == '1) ? v : v + cnt_t'(1);
	endfunction

	function automatic int unsigned idle_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return $urandom_range(1, 3);
		else if (pick < 96)
			return $urandom_range(4, 8);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic take_kind(input logic [7:0] b, input logic [POS_W-1:0] at);
		if (at >= opt_limit || b == OPT_EOL)
			walk_phase = ST_IDLE;
		else if (b == OPT_NOP)
			walk_phase = ST_KIND;
		else if (b == OPT_SACK)
			walk_phase = ST_SACK_LEN;
		else
			walk_phase = ST_OPT_LEN;
	endtask

	task automatic walk_frame_byte(input logic [7:0] b, input logic last);
		logic [POS_W-1:0] at;
		logic [4:0] n_pairs;
		sack_range_t r;
		at = walk_pos;
		case (walk_phase)
			ST_ETH: begin
				if (at == 12)
					etype_hi = b;
				else if (at == 13)
					walk_phase = (etype_hi == ETYPE_IPV4[15:8] && b == ETYPE_IPV4[7:0]) ?
						ST_IP : ST_IDLE;
			end
			ST_IP: begin
				if (at == 14)
					tcp_base = 8'd14 + {2'b00, b[3:0], 2'b00};
				else if (at == 23)
					walk_phase = (b == PROTO_TCP) ? ST_TCP : ST_IDLE;
			end
			ST_TCP: begin
				if (at == tcp_base + 12) begin
					opt_limit = tcp_base + {2'b00, b[7:4], 2'b00};
					walk_phase = ST_OPT_WAIT;
				end
			end
			ST_OPT_WAIT: begin
				if (at == tcp_base + 20)
					take_kind(b, at);
			end
			ST_KIND: take_kind(b, at);
			ST_OPT_LEN: begin
				if (b < 8'd2) begin
					walk_phase = ST_IDLE;
				end else if (b == 8'd2) begin
					walk_phase = ST_KIND;
				end else begin
					skip_left = b - 8'd2;
					walk_phase = ST_SKIP;
				end
			end
			ST_SKIP: begin
				skip_left = skip_left - 8'd1;
				if (skip_left == 8'd0)
					walk_phase = ST_KIND;
			end
			ST_SACK_LEN: begin
				n_pairs = (b < 8'd2) ? 5'd0 : 5'((b - 8'd2) >> 3);
				if (n_pairs == 5'd1)
					one_cnt = saturating_up(one_cnt);
				else if (n_pairs == 5'd2)
					two_cnt = saturating_up(two_cnt);
				else if (n_pairs == 5'd3)
					three_cnt = saturating_up(three_cnt);
				if (n_pairs == 5'd0) begin
					walk_phase = ST_KIND;
				end else begin
					pairs_left = n_pairs;
					edge_acc = 64'd0;
					edge_cnt = 3'd0;
					walk_phase = ST_EDGES;
				end
			end
			ST_EDGES: begin
				edge_acc = {edge_acc[55:0], b};
				if (edge_cnt == 3'd7) begin
					edge_cnt = 3'd0;
					range_cnt = saturating_up(range_cnt);
					r.left_edge = edge_acc[63:32];
					r.right_edge = edge_acc[31:0];
					r.range_number = range_cnt;
					r.one_count = one_cnt;
					r.two_count = two_cnt;
					r.three_count = three_cnt;
					sack_ranges_due.push_back(r);
					edge_acc = 64'd0;
					pairs_left = pairs_left - 5'd1;
					if (pairs_left == 5'd0)
						walk_phase = ST_KIND;
				end else begin
					edge_cnt = edge_cnt + 3'd1;
				end
			end
			default: walk_phase = ST_IDLE;
		endcase
		if (at != '1)
			walk_pos = at + 1'b1;
		if (last) begin
			walk_pos = '0;
			walk_phase = ST_ETH;
			etype_hi = 8'h00;
			tcp_base = 8'h00;
			opt_limit = 8'h00;
			skip_left = 8'h00;
			pairs_left = 5'd0;
			edge_acc = 64'd0;
			edge_cnt = 3'd0;
		end
	endtask

	task automatic add_sack(input logic [7:0] len);
		int unsigned n_pairs;
		logic [31:0] word;
		n_pairs = (len < 8'd2) ? 0 : (int'(len) - 2) / 8;
		opt_buf.push_back(OPT_SACK);
		opt_buf.push_back(len);
		for (int i = 0; i < 2 * n_pairs; i++) begin
			case ($urandom_range(0, 7))
				0: word = 32'h0000_0000;
				1: word = 32'hFFFF_FFFF;
				default: word = $urandom;
			endcase
			for (int k = 3; k >= 0; k--)
				opt_buf.push_back(word[8*k +: 8]);
		end
	endtask

	task automatic add_other(input logic [7:0] kind, input logic [7:0] len);
		opt_buf.push_back(kind);
		opt_buf.push_back(len);
		for (int i = 2; i < int'(len); i++)
			opt_buf.push_back(8'($urandom));
	endtask

	task automatic send_frame(input logic [15:0] etype, input logic [3:0] ihl,
		input logic [7:0] proto, input logic [3:0] doff, input int unsigned tail,
		input int unsigned cut);
		logic [7:0] bytes_out[$];
		int unsigned tcp_at;
		frame_item_t item;
		tcp_at = 14 + 4 * int'(ihl);
		for (int i = 0; i < tcp_at + 20; i++)
			bytes_out.push_back(8'($urandom));
		bytes_out[12] = etype[15:8];
		bytes_out[13] = etype[7:0];
		bytes_out[14] = {4'($urandom), ihl};
		bytes_out[23] = proto;
		bytes_out[tcp_at + 12] = {doff, 4'($urandom)};
		foreach (opt_buf[i])
			bytes_out.push_back(opt_buf[i]);
		for (int i = 0; i < tail; i++)
			bytes_out.push_back(8'($urandom));
		if (cut != 0) begin
			while (bytes_out.size() > cut)
				void'(bytes_out.pop_back());
		end
		foreach (bytes_out[i]) begin
			item.data = bytes_out[i];
			item.last = (i == bytes_out.size() - 1);
			frame_items.push_back(item);
		end
		opt_buf.delete();
	endtask

	task automatic random_option();
		int unsigned pick;
		logic [7:0] kind;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			add_sack(8'(2 + 8 * $urandom_range(1, 3)));
		end else if (pick < 44) begin
			add_sack(8'(2 + 8 * $urandom_range(4, 6)));
		end else if (pick < 47) begin
			add_sack(8'($urandom_range(0, 1)));
		end else if (pick < 51) begin
			add_sack(8'(2 + 8 * $urandom_range(0, 3) + $urandom_range(1, 7)));
		end else if (pick < 53) begin
			add_sack(8'($urandom));
		end else if (pick < 72) begin
			opt_buf.push_back(OPT_NOP);
		end else if (pick < 75) begin
			opt_buf.push_back(OPT_EOL);
		end else begin
			kind = 8'($urandom_range(2, 255));
			if (kind == OPT_SACK)
				kind = OPT_MSS;
			else if (pick < 80)
				kind = OPT_TSTAMP;
			add_other(kind, (pick < 95) ? 8'($urandom_range(2, 10)) : 8'($urandom_range(0, 1)));
		end
	endtask

	task automatic random_frame();
		logic [15:0] etype;
		logic [7:0] proto;
		logic [3:0] ihl;
		logic [3:0] doff;
		int unsigned pick;
		int unsigned opt_n;
		etype = ETYPE_IPV4;
		proto = PROTO_TCP;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			etype = 16'($urandom);
		else if (pick < 10)
			proto = 8'($urandom);
		ihl = ($urandom_range(0, 99) < 85) ? 4'd5 : 4'($urandom);
		repeat ($urandom_range(0, 5))
			random_option();
		opt_n = opt_buf.size();
		if ($urandom_range(0, 4) == 0)
			doff = 4'($urandom);
		else if (opt_n > 40)
			doff = 4'd15;
		else
			doff = 4'(5 + (opt_n + 3) / 4);
		send_frame(etype, ihl, proto, doff, $urandom_range(0, 24),
			($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : 0);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("status: fail");
		$finish;
	end

	// Frame byte driver.
	int unsigned tx_gap = 0;
	logic tx_calm = 1'b0;
	int unsigned tx_calm_left = 0;

	always @(posedge clk or negedge arst_n) begin
		frame_item_t item;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data <= 8'h00;
			byte_last <= 1'b0;
			tx_gap <= 0;
			tx_calm <= 1'b0;
			tx_calm_left <= 0;
		end else begin
			if (tx_calm_left == 0) begin
				tx_calm <= ($urandom_range(0, 2) == 0);
				tx_calm_left <= $urandom_range(30, 200);
			end else begin
				tx_calm_left <= tx_calm_left - 1;
			end
			if (!byte_valid || frame_if.ready) begin
				if (tx_gap != 0) begin
					byte_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (frame_items.size() != 0) begin
					item = frame_items.pop_front();
					byte_valid <= 1'b1;
					byte_data <= item.data;
					byte_last <= item.last;
					tx_gap <= (tx_calm || $urandom_range(0, 3) != 0) ? 0 : idle_len();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver with random stalls and two long hold-offs.
	int unsigned rx_stall = 0;
	logic rx_calm = 1'b0;
	int unsigned rx_calm_left = 0;
	int unsigned hold_left = 0;
	int unsigned holds_done = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sack_ready <= 1'b0;
			rx_stall <= 0;
			rx_calm <= 1'b0;
			rx_calm_left <= 0;
			hold_left <= 0;
			holds_done <= 0;
		end else begin
			if (rx_calm_left == 0) begin
				rx_calm <= ($urandom_range(0, 2) == 0);
				rx_calm_left <= $urandom_range(30, 200);
			end else begin
				rx_calm_left <= rx_calm_left - 1;
			end
			if (hold_left != 0) begin
				sack_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (holds_done < 2 && ranges_checked >= ((holds_done == 0) ? 5 : 40)) begin
				sack_ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				holds_done <= holds_done + 1;
			end else if (rx_stall != 0) begin
				sack_ready <= 1'b0;
				rx_stall <= rx_stall - 1;
			end else begin
				sack_ready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 5) == 0)
					rx_stall <= idle_len();
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %08h, actual %08h", $time, name, want, got);
			errors++;
		end
	endtask

	// Prediction on every byte transfer and comparison on every result transfer.
	always @(posedge clk) begin
		sack_range_t want;
		if (arst_n) begin
			if (byte_valid && frame_if.ready)
				walk_frame_byte(byte_data, byte_last);
			if (sack_if.valid && sack_ready) begin
				if (sack_ranges_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual left %08h right %08h",
						$time, sack_if.left_edge, sack_if.right_edge);
					errors++;
				end else begin
					want = sack_ranges_due.pop_front();
					check_field("left_edge", want.left_edge, sack_if.left_edge);
					check_field("right_edge", want.right_edge, sack_if.right_edge);
					check_field("range_number", want.range_number, sack_if.range_number);
					check_field("one_range_count", want.one_count, sack_if.one_range_count);
					check_field("two_range_count", want.two_count, sack_if.two_range_count);
					check_field("three_range_count", want.three_count, sack_if.three_range_count);
				end
				ranges_checked <= ranges_checked + 1;
			end
		end
	end

	initial begin
		// Four ranges behind the usual NOP padding; the one-, two- and three-range counters do not move.
		opt_buf.push_back(OPT_NOP);
		opt_buf.push_back(OPT_NOP);
		add_sack(8'd34);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd15, 8, 0);
		// Frames that are not IPv4 or not TCP are dropped.
		add_sack(8'd10);
		send_frame(ETYPE_IPV6, 4'd5, PROTO_TCP, 4'd8, 4, 0);
		add_sack(8'd10);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_UDP, 4'd8, 4, 0);
		// A data offset of five leaves no option area.
		add_sack(8'd10);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 4, 0);
		// Zero header length; the SACK option starts in the area and runs past its end.
		opt_buf.push_back(OPT_NOP);
		opt_buf.push_back(OPT_NOP);
		add_sack(8'd18);
		opt_buf.push_back(OPT_NOP);
		add_sack(8'd10);
		send_frame(ETYPE_IPV4, 4'd0, PROTO_TCP, 4'd6, 6, 0);
		// End of list stops the walk.
		opt_buf.push_back(OPT_EOL);
		add_sack(8'd10);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd9, 0, 0);
		// An ordinary option with a length below two stops the walk.
		add_other(OPT_TSTAMP, 8'd1);
		add_sack(8'd10);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd9, 0, 0);
		// Ordinary options are skipped by their length.
		add_other(OPT_MSS, 8'd2);
		add_other(OPT_TSTAMP, 8'd10);
		add_sack(8'd10);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd11, 2, 0);
		// SACK lengths of zero and one carry no range and the walk goes on.
		add_sack(8'd0);
		add_sack(8'd1);
		add_sack(8'd10);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd9, 0, 0);
		// A SACK length that is not a whole number of pairs.
		add_sack(8'd13);
		opt_buf.push_back(OPT_NOP);
		add_sack(8'd18);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd14, 0, 0);
		// A SACK kind exactly at the end of the option area is not parsed.
		repeat (4)
			opt_buf.push_back(OPT_NOP);
		add_sack(8'd10);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd6, 0, 0);
		// A frame cut inside the second pair, then a clean frame.
		opt_buf.push_back(OPT_NOP);
		opt_buf.push_back(OPT_NOP);
		add_sack(8'd18);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd10, 0, 69);
		add_sack(8'd10);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd8, 3, 0);
		// Largest SACK length reads far into the payload.
		opt_buf.push_back(OPT_NOP);
		opt_buf.push_back(OPT_NOP);
		add_sack(8'd255);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd15, 4, 0);
		// Three ranges in a single option.
		add_sack(8'd26);
		send_frame(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd12, 0, 0);

		while (frame_items.size() < 1500)
			random_frame();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (frame_items.size() != 0 || byte_valid)
			@(posedge clk);
		while (sack_ranges_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
